FILE: rtl/jsu_pkg.sv
// jsu_pkg: shared types and constants of the jacobi symbol unit
// payload structs, status structs and symbol codes; no dependencies

package jsu_pkg;

  localparam int FIELD_WIDTH       = 64;
  localparam int DEF_OPERAND_WIDTH = 64;

  typedef struct packed {
    logic [FIELD_WIDTH-1:0] operand;
    logic [FIELD_WIDTH-1:0] modulus;
  } req_t;

  typedef struct packed {
    logic signed [1:0] symbol;
    logic              invalid;
  } rsp_t;

  typedef struct packed {
    logic busy;
    logic done;
  } rem_stat_t;

  typedef struct packed {
    logic idle;
    logic done;
  } core_stat_t;

  localparam logic signed [1:0] SYM_ZERO = 2'sd0;
  localparam logic signed [1:0] SYM_POS  = 2'sd1;
  localparam logic signed [1:0] SYM_NEG  = -2'sd1;

  localparam logic [2:0] MOD8_THREE = 3'd3;
  localparam logic [2:0] MOD8_FIVE  = 3'd5;
  localparam logic [1:0] MOD4_THREE = 2'd3;

endpackage

FILE: rtl/jsu_rem.sv
// jsu_rem: bit-serial restoring remainder unit, one dividend bit per cycle
// depends on jsu_pkg for the status struct

module jsu_rem import jsu_pkg::*; #(
  parameter int OPERAND_WIDTH = DEF_OPERAND_WIDTH
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  input  logic [OPERAND_WIDTH-1:0] dividend,
  input  logic [OPERAND_WIDTH-1:0] divisor,
  output rem_stat_t                stat,
  output logic [OPERAND_WIDTH-1:0] rem
);

  localparam int CNT_WIDTH = $clog2(OPERAND_WIDTH + 1);

  logic                     busy;
  logic                     done;
  logic [CNT_WIDTH-1:0]     cnt;
  logic [OPERAND_WIDTH-1:0] acc;
  logic [OPERAND_WIDTH-1:0] quo;
  logic [OPERAND_WIDTH-1:0] div;
  logic [OPERAND_WIDTH:0]   trial;
  logic [OPERAND_WIDTH:0]   diff;
  logic                     ge;

  assign trial = {acc, quo[OPERAND_WIDTH-1]};
  assign diff  = trial - {1'b0, div};
  assign ge    = trial >= {1'b0, div};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_WIDTH'(OPERAND_WIDTH);
      end else if (busy) begin
        cnt <= cnt - CNT_WIDTH'(1);
        if (cnt == CNT_WIDTH'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      acc <= '0;
      quo <= dividend;
      div <= divisor;
    end else if (busy) begin
      acc <= ge ? diff[OPERAND_WIDTH-1:0] : trial[OPERAND_WIDTH-1:0];
      quo <= {quo[OPERAND_WIDTH-2:0], 1'b0};
    end
  end

  assign stat = '{busy: busy, done: done};
  assign rem  = acc;

`ifndef SYNTHESIS
  a_partial_below_divisor: assert property (@(posedge clk) disable iff (rst)
    busy |-> acc < div)
    else $error("partial remainder not below divisor");

  a_no_restart: assert property (@(posedge clk) disable iff (rst)
    start |-> !busy)
    else $error("remainder unit restarted while busy");
`endif

endmodule

FILE: rtl/jsu_core.sv
// jsu_core: reduction sequencer, strips twos, tracks the sign, swaps a and n
// depends on jsu_pkg and on jsu_rem for the n mod a step

module jsu_core import jsu_pkg::*; #(
  parameter int OPERAND_WIDTH = DEF_OPERAND_WIDTH
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  input  logic [OPERAND_WIDTH-1:0] a_in,
  input  logic [OPERAND_WIDTH-1:0] n_in,
  input  logic                     ack,
  output core_stat_t               stat,
  output rsp_t                     result
);

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_CHECK = 5'b00010,
    ST_STRIP = 5'b00100,
    ST_DIV   = 5'b01000,
    ST_DONE  = 5'b10000
  } state_t;

  localparam logic [OPERAND_WIDTH-1:0] ONE   = OPERAND_WIDTH'(1);
  localparam logic [OPERAND_WIDTH-1:0] THREE = OPERAND_WIDTH'(3);

  state_t                   state, state_next;
  logic [OPERAND_WIDTH-1:0] a, a_next;
  logic [OPERAND_WIDTH-1:0] n, n_next;
  logic                     neg, neg_next;
  logic                     twos, twos_next;
  rsp_t                     res, res_next;
  logic                     div_start;
  logic                     flip;
  logic                     bad_in;
  logic                     flip_neg;
  rem_stat_t                rem_stat;
  logic [OPERAND_WIDTH-1:0] rem;

  jsu_rem #(.OPERAND_WIDTH(OPERAND_WIDTH)) u_rem (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (n),
    .divisor  (a),
    .stat     (rem_stat),
    .rem      (rem)
  );

  assign bad_in = !n_in[0] || (n_in < THREE) || (a_in > n_in);
  assign flip   = (twos && (n[2:0] == MOD8_THREE || n[2:0] == MOD8_FIVE))
                ^ (a[1:0] == MOD4_THREE && n[1:0] == MOD4_THREE);
  assign flip_neg = neg ^ flip;

  always_comb begin
    state_next = state;
    a_next     = a;
    n_next     = n;
    neg_next   = neg;
    twos_next  = twos;
    res_next   = res;
    div_start  = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (start) begin
          if (bad_in) begin
            res_next   = '{symbol: SYM_ZERO, invalid: 1'b1};
            state_next = ST_DONE;
          end else begin
            a_next     = a_in;
            n_next     = n_in;
            neg_next   = 1'b0;
            state_next = ST_CHECK;
          end
        end
      end
      ST_CHECK: begin
        twos_next = 1'b0;
        if (a == '0) begin
          res_next   = '{symbol: SYM_ZERO, invalid: 1'b0};
          state_next = ST_DONE;
        end else if (a == ONE) begin
          res_next   = '{symbol: (neg ? SYM_NEG : SYM_POS), invalid: 1'b0};
          state_next = ST_DONE;
        end else begin
          state_next = ST_STRIP;
        end
      end
      ST_STRIP: begin
        if (!a[0]) begin
          a_next    = a >> 1;
          twos_next = !twos;
        end else begin
          neg_next = flip_neg;
          if (a == ONE) begin
            res_next   = '{symbol: (flip_neg ? SYM_NEG : SYM_POS), invalid: 1'b0};
            state_next = ST_DONE;
          end else begin
            div_start  = 1'b1;
            state_next = ST_DIV;
          end
        end
      end
      ST_DIV: begin
        if (rem_stat.done) begin
          n_next     = a;
          a_next     = rem;
          state_next = ST_CHECK;
        end
      end
      ST_DONE: begin
        if (ack) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      neg   <= 1'b0;
      twos  <= 1'b0;
    end else begin
      state <= state_next;
      neg   <= neg_next;
      twos  <= twos_next;
    end
  end

  always_ff @(posedge clk) begin
    a   <= a_next;
    n   <= n_next;
    res <= res_next;
  end

  assign stat   = '{idle: (state == ST_IDLE), done: (state == ST_DONE)};
  assign result = res;

`ifndef SYNTHESIS
  a_divisor_odd: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DIV) |-> (a[0] && a != ONE))
    else $error("remainder step with even or unit divisor");

  a_reduction_shrinks: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DIV && rem_stat.done) |=> a < n)
    else $error("reduction round did not shrink operand");
`endif

endmodule

FILE: rtl/jacobi_symbol_unit.sv
// jacobi_symbol_unit: top level, request handshake and result register
// depends on jsu_pkg and jsu_core
//
// usage:
//   req channel: operand a and modulus n, transfer when req_valid and !req_stall
//   rsp channel: symbol (-1, 0, 1) and invalid, transfer when rsp_valid and
//     !rsp_stall; one result per request, in order
//   only the low OPERAND_WIDTH bits of operand and modulus are used
//   an even modulus, a modulus below 3 or an operand above the modulus gives
//     invalid = 1 with symbol 0, with no reduction round
//   otherwise each reduction round passes the check state, one strip step
//     per stripped factor of two plus one, and the bit-serial remainder
//     unit, which sets the pace; the round count is at most about
//     1.5 * OPERAND_WIDTH, typically a fraction of that
//   one request is worked on at a time: req_stall is high from the
//     transfer until the result is moved into the output register
//   a stalled result holds in the output register; a finished next result
//     waits in the core until the register is free
//   reset (rst, synchronous) empties the output register and idles the core

module jacobi_symbol_unit import jsu_pkg::*; #(
  parameter int OPERAND_WIDTH = DEF_OPERAND_WIDTH
) (
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_stall,
  input  req_t req,
  output logic rsp_valid,
  input  logic rsp_stall,
  output rsp_t rsp
);

  core_stat_t core_stat;
  rsp_t       core_result;
  logic       start;
  logic       load;

  assign req_stall = !core_stat.idle;
  assign start     = req_valid && core_stat.idle;
  assign load      = core_stat.done && (!rsp_valid || !rsp_stall);

  jsu_core #(.OPERAND_WIDTH(OPERAND_WIDTH)) u_core (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .a_in   (req.operand[OPERAND_WIDTH-1:0]),
    .n_in   (req.modulus[OPERAND_WIDTH-1:0]),
    .ack    (load),
    .stat   (core_stat),
    .result (core_result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (load) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      rsp <= core_result;
    end
  end

`ifndef SYNTHESIS
  a_invalid_zero: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp.invalid) |-> rsp.symbol == SYM_ZERO)
    else $error("invalid result with nonzero symbol");
`endif

endmodule

FILE: test/jsu_symbol_checker.sv
// jsu_symbol_checker: watches both channels of jacobi_symbol_unit, predicts each
// result and compares it with the transfer that comes back; reports a failure count
// depends on jsu_pkg

module jsu_symbol_checker import jsu_pkg::*; #(
  parameter int OPERAND_WIDTH = DEF_OPERAND_WIDTH
) (
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  input  logic req_stall,
  input  req_t req,
  input  logic rsp_valid,
  input  logic rsp_stall,
  input  rsp_t rsp,
  input  logic wrap_up,
  output int   outstanding,
  output int   failures
);
  timeunit 1ns;
  timeprecision 1ps;

  rsp_t expected_symbols[$];
  int   fail_tally = 0;
  bit   leftovers_done = 1'b0;

  function automatic logic signed [1:0] flip(logic signed [1:0] s);
    return (s == SYM_POS) ? SYM_NEG : SYM_POS;
  endfunction

  function automatic rsp_t jacobi_of(req_t item);
    logic [63:0]       mask;
    logic [63:0]       a;
    logic [63:0]       n;
    logic [63:0]       rem;
    logic signed [1:0] s;
    int                twos;
    bit                done;
    rsp_t              res;
    mask = (OPERAND_WIDTH >= 64) ? '1 : ((64'd1 << OPERAND_WIDTH) - 64'd1);
    a = item.operand & mask;
    n = item.modulus & mask;
    res.symbol = SYM_ZERO;
    res.invalid = 1'b0;
    if (!n[0] || n < 64'd3 || a > n) begin
      res.invalid = 1'b1;
      return res;
    end
    s = SYM_POS;
    done = 1'b0;
    while (!done) begin
      if (a == 64'd0) begin
        s = SYM_ZERO;
        done = 1'b1;
      end else if (a == 64'd1) begin
        done = 1'b1;
      end else begin
        twos = 0;
        while (!a[0]) begin
          a = a >> 1;
          twos++;
        end
        if (twos[0] && (n[2:0] == MOD8_THREE || n[2:0] == MOD8_FIVE))
          s = flip(s);
        if (a[1:0] == MOD4_THREE && n[1:0] == MOD4_THREE)
          s = flip(s);
        if (a == 64'd1) begin
          done = 1'b1;
        end else begin
          rem = n % a;
          n = a;
          a = rem;
        end
      end
    end
    res.symbol = s;
    return res;
  endfunction

  always @(posedge clk) begin
    rsp_t want;
    if (!rst) begin
      if (req_valid && !req_stall)
        expected_symbols.push_back(jacobi_of(req));
      if (rsp_valid && !rsp_stall) begin
        if (expected_symbols.size() == 0) begin
          $error("unexpected result transfer: symbol %0d invalid %0b", rsp.symbol, rsp.invalid);
          fail_tally++;
        end else begin
          want = expected_symbols.pop_front();
          if (rsp.symbol !== want.symbol) begin
            $error("symbol mismatch: expected %0d actual %0d", want.symbol, rsp.symbol);
            fail_tally++;
          end
          if (rsp.invalid !== want.invalid) begin
            $error("invalid mismatch: expected %0b actual %0b", want.invalid, rsp.invalid);
            fail_tally++;
          end
        end
      end
      if (wrap_up && !leftovers_done) begin
        leftovers_done = 1'b1;
        if (expected_symbols.size() != 0) begin
          $error("%0d expected results never arrived", expected_symbols.size());
          fail_tally += expected_symbols.size();
        end
      end
    end
    outstanding <= expected_symbols.size();
    failures <= fail_tally;
  end

endmodule

FILE: test/tb_jacobi_symbol_unit.sv
// tb_jacobi_symbol_unit: stimulus, idling and verdict for jacobi_symbol_unit
// depends on jsu_pkg, jacobi_symbol_unit and jsu_symbol_checker

module tb_jacobi_symbol_unit;
  import jsu_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int OPERAND_WIDTH  = DEF_OPERAND_WIDTH;
  localparam int RANDOM_ITEMS   = 1200;
  localparam int WATCHDOG_LIMIT = 50000;
  localparam int DRAIN_CYCLES   = 8 * (OPERAND_WIDTH + 2);
  localparam logic [63:0] ALL_ONES = '1;

  logic clk;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_stall;
  req_t req = '0;
  logic rsp_valid;
  logic rsp_stall = 1'b0;
  rsp_t rsp;
  logic wrap_up = 1'b0;
  bit   steady = 1'b0;
  int   outstanding;
  int   failures;
  int   idle_cycles = 0;
  int   requests_moved = 0;
  int   results_moved = 0;
  int   invalid_results = 0;
  int   stall_left = 0;

  jacobi_symbol_unit #(.OPERAND_WIDTH(OPERAND_WIDTH)) u_top (
    .clk(clk), .rst(rst),
    .req_valid(req_valid), .req_stall(req_stall), .req(req),
    .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp(rsp)
  );

  jsu_symbol_checker #(.OPERAND_WIDTH(OPERAND_WIDTH)) u_checker (
    .clk(clk), .rst(rst),
    .req_valid(req_valid), .req_stall(req_stall), .req(req),
    .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp(rsp),
    .wrap_up(wrap_up), .outstanding(outstanding), .failures(failures)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic int pick_gap();
    int r;
    if (steady)
      return 0;
    r = $urandom_range(0, 99);
    if (r < 55)
      return 0;
    if (r < 90)
      return $urandom_range(1, 4);
    return $urandom_range(10, 80);
  endfunction

  function automatic logic [63:0] rand_word(int bits);
    logic [63:0] w;
    w = {$urandom, $urandom};
    if (bits < 64)
      w &= (64'd1 << bits) - 64'd1;
    return w;
  endfunction

  function automatic req_t make_req(logic [63:0] a, logic [63:0] n);
    req_t item;
    item.operand = a;
    item.modulus = n;
    return item;
  endfunction

  function automatic req_t make_valid_req(int bits);
    logic [63:0] a;
    logic [63:0] n;
    logic [63:0] f;
    n = rand_word(bits) | 64'd1;
    if (n < 64'd3)
      n = 64'd3;
    case ($urandom_range(0, 9))
      0: a = 64'd0;
      1: a = n;
      2: begin
        a = 64'd1 << $urandom_range(1, bits - 1);
        while (a > n)
          a = a >> 1;
      end
      3: begin
        // shared odd factor, so the symbol comes out zero
        f = rand_word(bits < 8 ? bits : 8) | 64'd3;
        n = f * (rand_word(bits > 8 ? bits - 8 : 1) | 64'd1);
        a = f * (rand_word(64) % (n / f) + 64'd1);
      end
      default: a = (n == ALL_ONES) ? rand_word(64) : rand_word(64) % (n + 64'd1);
    endcase
    return make_req(a, n);
  endfunction

  function automatic req_t make_bad_req(int bits);
    logic [63:0] a;
    logic [63:0] n;
    a = rand_word(bits);
    case ($urandom_range(0, 3))
      0: n = rand_word(bits) & ~64'd1;
      1: n = 64'($urandom_range(0, 2));
      2: begin
        n = rand_word(bits) | 64'd1;
        if (n == ALL_ONES)
          n = n - 64'd2;
        a = n + 64'd1 + rand_word(bits) % (ALL_ONES - n);
      end
      default: begin
        a = rand_word(64);
        n = rand_word(64);
      end
    endcase
    return make_req(a, n);
  endfunction

  task automatic send_request(input req_t item);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req <= item;
    req_valid <= 1'b1;
    @(posedge clk);
    while (req_stall) @(posedge clk);
  endtask

  // result side stalls
  always @(posedge clk) begin
    if (rst) begin
      rsp_stall <= 1'b0;
      stall_left = 0;
    end else if (stall_left > 0) begin
      stall_left--;
      rsp_stall <= 1'b1;
    end else if (!steady && $urandom_range(0, 5) == 0) begin
      stall_left = ($urandom_range(0, 4) == 0) ? $urandom_range(10, 80) : $urandom_range(0, 3);
      rsp_stall <= 1'b1;
    end else begin
      rsp_stall <= 1'b0;
    end
  end

  // watchdog and transfer counts
  always @(posedge clk) begin
    if (!rst) begin
      if (req_valid && !req_stall)
        requests_moved++;
      if (rsp_valid && !rsp_stall) begin
        results_moved++;
        if (rsp.invalid)
          invalid_results++;
      end
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("no transfer for %0d cycles", idle_cycles);
        $display("jacobi_symbol_unit test failed");
        $finish;
      end
    end
  end

  initial begin
    int bits;
    int r;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    send_request(make_req(64'd0, 64'd3));
    send_request(make_req(64'd1, 64'd3));
    send_request(make_req(64'd2, 64'd3));
    send_request(make_req(64'd3, 64'd3));
    send_request(make_req(64'd2, 64'd5));
    send_request(make_req(64'd2, 64'd7));
    send_request(make_req(64'd2, 64'd9));
    send_request(make_req(64'd4, 64'd7));
    send_request(make_req(64'd3, 64'd7));
    send_request(make_req(64'd7, 64'd11));
    send_request(make_req(64'd15, 64'd45));
    send_request(make_req(64'd1, 64'd4));
    send_request(make_req(64'd0, 64'd0));
    send_request(make_req(64'd1, 64'd1));
    send_request(make_req(64'd1, 64'd2));
    send_request(make_req(64'd5, 64'd3));
    send_request(make_req(ALL_ONES, ALL_ONES));
    send_request(make_req(ALL_ONES - 64'd1, ALL_ONES));
    send_request(make_req(64'd0, ALL_ONES));
    send_request(make_req(64'h8000_0000_0000_0000, ALL_ONES));
    send_request(make_req(64'd2, 64'hFFFF_FFFF_FFFF_FFC5));
    send_request(make_req(64'h5555_5555_5555_5555, 64'h8000_0000_0000_0001));
    send_request(make_req(ALL_ONES, ALL_ONES - 64'd1));
    send_request(make_req(ALL_ONES, 64'h7FFF_FFFF_FFFF_FFFF));

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      steady <= ((i / 150) % 3 == 1);
      r = $urandom_range(0, 99);
      bits = (r < 8) ? 64 : $urandom_range(2, 16);
      if ($urandom_range(0, 9) == 0)
        send_request(make_bad_req(bits));
      else
        send_request(make_valid_req(bits));
    end
    req_valid <= 1'b0;
    steady <= 1'b0;

    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    wrap_up <= 1'b1;
    repeat (2) @(posedge clk);

    $display("%0d requests and %0d results moved, %0d of them flagged invalid",
             requests_moved, results_moved, invalid_results);
    $display("directed corner operands and moduli, then random small and full width items");
    if (failures == 0)
      $display("jacobi_symbol_unit test passed");
    else
      $display("jacobi_symbol_unit test failed");
    $finish;
  end

endmodule
